[rtl/dsfc_pkg.sv]
package dsfc_pkg;

	// Number formats
	localparam int unsigned DIST_BITS = 20;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned QB        = FRAC_BITS + 1;          // fraction incl. 1.0
	localparam int unsigned SPAN_W    = DIST_BITS + 1;          // band ends and spans
	localparam int unsigned NUM_W     = DIST_BITS + QB;         // dividend width
	localparam int unsigned CS_W      = 8 + QB;                 // channel times shade
	localparam int unsigned SP_W      = CS_W + 10;              // times gain
	localparam int unsigned BL_W      = 8 + QB + 1;             // blend sum
	localparam int unsigned IN_DATA_W = ((32 + DIST_BITS + 7) / 8) * 8;

	// Shade levels, Q0.FRAC_BITS, rounded to nearest
	localparam int unsigned K65_I = ((65 << FRAC_BITS) + 50) / 100;
	localparam int unsigned K35_I = ((35 << FRAC_BITS) + 50) / 100;

	localparam logic [QB-1:0] ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [QB-1:0] K65_Q   = QB'(K65_I);
	localparam logic [QB-1:0] K35_Q   = QB'(K35_I);
	localparam logic [QB-1:0] DROP1_Q = ONE_Q - K65_Q;
	localparam logic [QB-1:0] DROP2_Q = K65_Q - K35_Q;

	// Register reset values
	localparam logic [DIST_BITS-1:0] RST_SHADE_START      = DIST_BITS'(2048);
	localparam logic [DIST_BITS-1:0] RST_SHADE_MIST_START = DIST_BITS'(4096);
	localparam logic [DIST_BITS-1:0] RST_MIST_FULL        = DIST_BITS'(8192);
	localparam logic [9:0]           RST_COLOR_GAIN       = 10'd256;
	localparam logic [7:0]           RST_MIST_RED         = 8'd153;
	localparam logic [7:0]           RST_MIST_GREEN       = 8'd193;
	localparam logic [7:0]           RST_MIST_BLUE        = 8'd237;

	// Register index, byte address / 4
	typedef enum logic [2:0] {
		REG_SHADE_START,
		REG_SHADE_MIST_START,
		REG_MIST_FULL,
		REG_NO_MIST,
		REG_COLOR_GAIN,
		REG_MIST_RED,
		REG_MIST_GREEN,
		REG_MIST_BLUE
	} reg_idx_t;

	// Which piece of the distance curve an item falls in
	typedef enum logic [1:0] {
		BAND_NEAR,
		BAND_SHADE,
		BAND_MIST,
		BAND_FAR
	} band_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} color_t;

	typedef struct packed {
		color_t col;
		band_t  band;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [NUM_W-1:0]  num_a;   // offset * band drop + span/2
		logic [NUM_W-1:0]  num_b;   // offset * 1.0 + span/2
		logic [SPAN_W-1:0] den;
	} div_in_t;

	typedef struct packed {
		side_t         side;
		logic [QB-1:0] q_a;
		logic [QB-1:0] q_b;
	} div_out_t;

endpackage

[rtl/dsfc_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Both lanes share the divisor. Requires num >> QB < den (quotient fits QB bits).
module dsfc_div import dsfc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  div_in_t  in_req,
	output logic     out_valid,
	input  logic     out_ready,
	output div_out_t out_res
);

	typedef struct packed {
		side_t             side;
		logic [SPAN_W-1:0] rem_a;
		logic [QB-1:0]     lq_a;
		logic [SPAN_W-1:0] rem_b;
		logic [QB-1:0]     lq_b;
		logic [SPAN_W-1:0] den;
	} div_st_t;

	div_st_t       step_s [QB];
	div_st_t       step_nxt [QB];
	div_st_t       init;
	logic [QB-1:0] vld_s;
	logic          en;

	// one restoring step: shift in next dividend bit, try subtract
	function automatic logic [SPAN_W+QB-1:0] div_step(
		input logic [SPAN_W-1:0] rem,
		input logic [QB-1:0]     lq,
		input logic [SPAN_W-1:0] den
	);
		logic [SPAN_W-1:0] sh;
		logic              ge;
		sh = {rem[SPAN_W-2:0], lq[QB-1]};
		ge = (sh >= den);
		return {(ge ? sh - den : sh), lq[QB-2:0], ge};
	endfunction

	// whole segment advances together
	assign en       = !vld_s[QB-1] || out_ready;
	assign in_ready = en;

	// initial remainder is the upper dividend part
	always_comb begin
		init.side  = in_req.side;
		init.rem_a = {1'b0, in_req.num_a[NUM_W-1:QB]};
		init.lq_a  = in_req.num_a[QB-1:0];
		init.rem_b = {1'b0, in_req.num_b[NUM_W-1:QB]};
		init.lq_b  = in_req.num_b[QB-1:0];
		init.den   = in_req.den;
	end

	// step logic for every stage
	always_comb begin
		for (int k = 0; k < QB; k++) begin
			step_nxt[k] = (k == 0) ? init : step_s[(k == 0) ? 0 : k - 1];
			{step_nxt[k].rem_a, step_nxt[k].lq_a} =
				div_step(step_nxt[k].rem_a, step_nxt[k].lq_a, step_nxt[k].den);
			{step_nxt[k].rem_b, step_nxt[k].lq_b} =
				div_step(step_nxt[k].rem_b, step_nxt[k].lq_b, step_nxt[k].den);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QB-2:0], in_valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				step_s[k] <= step_nxt[k];
			end
		end
	end

	assign out_valid    = vld_s[QB-1];
	assign out_res.side = step_s[QB-1].side;
	assign out_res.q_a  = step_s[QB-1].lq_a;
	assign out_res.q_b  = step_s[QB-1].lq_b;

endmodule

[rtl/distance_shade_fog_color.sv]
// Distance shading and linear fog for a stream of RGBA8 colors.
// Slave stream s_axis carries one vertex color and its camera distance per
// request; master stream m_axis returns the shaded, fogged color with alpha
// copied. Both transfer on tvalid && tready. Band ends, gain, mist color and
// the no_mist switch sit behind an APB port (pready tied high, reads return
// the stored value); change them only while the stream is drained.
// Throughput: one request per clock unless m_axis_tready is held low.
// Stages from acceptance to m_axis_tvalid: 4 front stages (capture, band
// select, drop multiply, rounding add), 17 divider stages (one quotient bit
// each, set by the fraction width plus one) and 6 back stages (shade/fog
// select, two gain multiplies, saturate, blend multiply, blend round).
// The pipeline runs as three segments (front, divider, back); each advances
// whenever its last stage is empty or drained, so a stalled receiver holds
// m_axis_tdata stable and back-pressure reaches s_axis_tready once the last
// stage of every segment holds a request; bubbles ahead of those stages stay.
// Nothing is dropped or repeated.
// Reset (arst_n low) empties the pipeline and loads the default registers;
// no clearing pass is needed; requests are taken right after release.
module distance_shade_fog_color import dsfc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// red[7:0], green[15:8], blue[23:16], alpha[31:24], view_distance above, zero pad
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
	output logic [31:0]          m_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [SP_W:0] SP_RND = (SP_W + 1)'(1) << (FRAC_BITS + 7);
	localparam logic [BL_W-1:0] BL_RND = BL_W'(1) << (FRAC_BITS - 1);

	// configuration registers
	logic [DIST_BITS-1:0] shade_start_q;
	logic [DIST_BITS-1:0] shade_mist_start_q;
	logic [DIST_BITS-1:0] mist_full_q;
	logic                 no_mist_q;
	logic [9:0]           color_gain_q;
	logic [7:0]           mist_red_q;
	logic [7:0]           mist_green_q;
	logic [7:0]           mist_blue_q;
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	// derived band ends
	logic [SPAN_W-1:0] e0p1, e1, e1p1, e2;
	logic [SPAN_W-1:0] e1_q, e2_q, span1_q, span2_q;

	// front segment
	logic                 en_f;
	logic                 v_s1, v_s2, v_s3, v_s4;
	color_t               col_s1, col_s2, col_s3, col_s4;
	logic [DIST_BITS-1:0] dist_s1;
	band_t                band_c, band_s2, band_s3, band_s4;
	logic [DIST_BITS-1:0] off_c, off_s2;
	logic [SPAN_W-1:0]    den_c, den_s2, den_s3, den_s4;
	logic [QB-1:0]        ka_c;
	logic [NUM_W-1:0]     num_a_s3, num_b_s3, num_a_s4, num_b_s4;
	logic [SPAN_W-1:0]    dist_x;
	logic [SPAN_W-1:0]    off_mist_x;

	// divider
	div_in_t  div_req;
	div_out_t div_res;
	logic     div_in_ready, div_vld;

	// back segment
	logic            en_b;
	logic            v_p1, v_p2, v_p3, v_p4, v_p5, v_p6;
	color_t          col_p1, col_p2, col_p3, col_p4, col_p5;
	logic [7:0]      alpha_p6;
	logic [QB-1:0]   shade_c, fog_c;
	logic [QB-1:0]   shade_p1, fog_p1, inv_p1;
	logic [QB-1:0]   fog_p2, inv_p2, fog_p3, inv_p3, fog_p4, inv_p4;
	logic [CS_W-1:0] cs_r_p2, cs_g_p2, cs_b_p2;
	logic [SP_W-1:0] sp_r_p3, sp_g_p3, sp_b_p3;
	logic [7:0]      sc_r_p4, sc_g_p4, sc_b_p4;
	logic [CS_W-1:0] ba_r_p5, ba_g_p5, ba_b_p5;
	logic [CS_W-1:0] bb_r_p5, bb_g_p5, bb_b_p5;
	logic [7:0]      out_r_p6, out_g_p6, out_b_p6;

	// round, scale down and saturate the gained channel
	function automatic logic [7:0] sat_scale(input logic [SP_W-1:0] p);
		logic [SP_W:0] t;
		t = {1'b0, p} + SP_RND;
		return (|t[SP_W:FRAC_BITS+16]) ? 8'hFF : t[FRAC_BITS+15:FRAC_BITS+8];
	endfunction

	// sum the blend terms, round and saturate
	function automatic logic [7:0] blend_out(
		input logic [CS_W-1:0] a,
		input logic [CS_W-1:0] b
	);
		logic [BL_W-1:0] t;
		t = {1'b0, a} + {1'b0, b} + BL_RND;
		return (|t[BL_W-1:FRAC_BITS+8]) ? 8'hFF : t[FRAC_BITS+7:FRAC_BITS];
	endfunction

	// ---------------------------------------------------------------
	// APB register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shade_start_q      <= RST_SHADE_START;
			shade_mist_start_q <= RST_SHADE_MIST_START;
			mist_full_q        <= RST_MIST_FULL;
			no_mist_q          <= 1'b0;
			color_gain_q       <= RST_COLOR_GAIN;
			mist_red_q         <= RST_MIST_RED;
			mist_green_q       <= RST_MIST_GREEN;
			mist_blue_q        <= RST_MIST_BLUE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SHADE_START:      shade_start_q      <= pwdata[DIST_BITS-1:0];
				REG_SHADE_MIST_START: shade_mist_start_q <= pwdata[DIST_BITS-1:0];
				REG_MIST_FULL:        mist_full_q        <= pwdata[DIST_BITS-1:0];
				REG_NO_MIST:          no_mist_q          <= pwdata[0];
				REG_COLOR_GAIN:       color_gain_q       <= pwdata[9:0];
				REG_MIST_RED:         mist_red_q         <= pwdata[7:0];
				REG_MIST_GREEN:       mist_green_q       <= pwdata[7:0];
				REG_MIST_BLUE:        mist_blue_q        <= pwdata[7:0];
				default:              ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_SHADE_START:      prdata = 32'(shade_start_q);
			REG_SHADE_MIST_START: prdata = 32'(shade_mist_start_q);
			REG_MIST_FULL:        prdata = 32'(mist_full_q);
			REG_NO_MIST:          prdata = 32'(no_mist_q);
			REG_COLOR_GAIN:       prdata = 32'(color_gain_q);
			REG_MIST_RED:         prdata = 32'(mist_red_q);
			REG_MIST_GREEN:       prdata = 32'(mist_green_q);
			REG_MIST_BLUE:        prdata = 32'(mist_blue_q);
			default:              prdata = '0;
		endcase
	end

	// effective band ends: each at least one past the previous
	always_comb begin
		e0p1 = {1'b0, shade_start_q} + SPAN_W'(1);
		e1   = ({1'b0, shade_mist_start_q} > e0p1) ? {1'b0, shade_mist_start_q} : e0p1;
		e1p1 = e1 + SPAN_W'(1);
		e2   = ({1'b0, mist_full_q} > e1p1) ? {1'b0, mist_full_q} : e1p1;
	end

	// user keeps registers static while items flow, block does not enforce it; refreshed every clock
	always_ff @(posedge clk) begin
		e1_q    <= e1;
		e2_q    <= e2;
		span1_q <= e1 - {1'b0, shade_start_q};
		span2_q <= e2 - e1;
	end

	// ---------------------------------------------------------------
	// front segment: capture, band select, multiply, rounding add
	assign en_f          = !v_s4 || div_in_ready;
	assign s_axis_tready = en_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en_f) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// band classification and offset into the band
	always_comb begin
		dist_x     = {1'b0, dist_s1};
		off_mist_x = dist_x - e1_q;
		if (!(dist_s1 > shade_start_q)) begin
			band_c = BAND_NEAR;
			off_c  = '0;
			den_c  = span1_q;
		end else if (dist_x <= e1_q) begin
			band_c = BAND_SHADE;
			off_c  = dist_s1 - shade_start_q;
			den_c  = span1_q;
		end else if (dist_x <= e2_q) begin
			band_c = BAND_MIST;
			off_c  = off_mist_x[DIST_BITS-1:0];
			den_c  = span2_q;
		end else begin
			band_c = BAND_FAR;
			off_c  = '0;
			den_c  = span2_q;
		end
	end

	// shade drop of the band
	always_comb begin
		case (band_s2)
			BAND_SHADE: ka_c = DROP1_Q;
			BAND_MIST:  ka_c = DROP2_Q;
			default:    ka_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			col_s1.red   <= s_axis_tdata[7:0];
			col_s1.green <= s_axis_tdata[15:8];
			col_s1.blue  <= s_axis_tdata[23:16];
			col_s1.alpha <= s_axis_tdata[31:24];
			dist_s1      <= s_axis_tdata[32+DIST_BITS-1:32];

			col_s2  <= col_s1;
			band_s2 <= band_c;
			off_s2  <= off_c;
			den_s2  <= den_c;

			col_s3   <= col_s2;
			band_s3  <= band_s2;
			den_s3   <= den_s2;
			num_a_s3 <= NUM_W'(off_s2) * NUM_W'(ka_c);
			num_b_s3 <= {1'b0, off_s2, {FRAC_BITS{1'b0}}};

			col_s4   <= col_s3;
			band_s4  <= band_s3;
			den_s4   <= den_s3;
			num_a_s4 <= num_a_s3 + NUM_W'(den_s3 >> 1);
			num_b_s4 <= num_b_s3 + NUM_W'(den_s3 >> 1);
		end
	end

	// ---------------------------------------------------------------
	// divider: shade drop and fog weight
	always_comb begin
		div_req.side.col  = col_s4;
		div_req.side.band = band_s4;
		div_req.num_a     = num_a_s4;
		div_req.num_b     = num_b_s4;
		div_req.den       = den_s4;
	end

	dsfc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.in_req    (div_req),
		.out_valid (div_vld),
		.out_ready (en_b),
		.out_res   (div_res)
	);

	// ---------------------------------------------------------------
	// back segment: shade and fog, gain, saturate, blend
	assign en_b = !v_p6 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_p4 <= 1'b0;
			v_p5 <= 1'b0;
			v_p6 <= 1'b0;
		end else if (en_b) begin
			v_p1 <= div_vld;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
			v_p5 <= v_p4;
			v_p6 <= v_p5;
		end
	end

	// shade factor and fog weight per band
	always_comb begin
		case (div_res.side.band)
			BAND_SHADE: begin
				shade_c = ONE_Q - div_res.q_a;
				fog_c   = '0;
			end
			BAND_MIST: begin
				shade_c = K65_Q - div_res.q_a;
				fog_c   = div_res.q_b;
			end
			BAND_FAR: begin
				shade_c = K35_Q;
				fog_c   = ONE_Q;
			end
			default: begin
				shade_c = ONE_Q;
				fog_c   = '0;
			end
		endcase
		if (no_mist_q) begin
			fog_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			col_p1   <= div_res.side.col;
			shade_p1 <= shade_c;
			fog_p1   <= fog_c;
			inv_p1   <= ONE_Q - fog_c;

			col_p2  <= col_p1;
			fog_p2  <= fog_p1;
			inv_p2  <= inv_p1;
			cs_r_p2 <= CS_W'(col_p1.red) * CS_W'(shade_p1);
			cs_g_p2 <= CS_W'(col_p1.green) * CS_W'(shade_p1);
			cs_b_p2 <= CS_W'(col_p1.blue) * CS_W'(shade_p1);

			col_p3  <= col_p2;
			fog_p3  <= fog_p2;
			inv_p3  <= inv_p2;
			sp_r_p3 <= SP_W'(cs_r_p2) * SP_W'(color_gain_q);
			sp_g_p3 <= SP_W'(cs_g_p2) * SP_W'(color_gain_q);
			sp_b_p3 <= SP_W'(cs_b_p2) * SP_W'(color_gain_q);

			col_p4  <= col_p3;
			fog_p4  <= fog_p3;
			inv_p4  <= inv_p3;
			sc_r_p4 <= sat_scale(sp_r_p3);
			sc_g_p4 <= sat_scale(sp_g_p3);
			sc_b_p4 <= sat_scale(sp_b_p3);

			col_p5  <= col_p4;
			ba_r_p5 <= CS_W'(sc_r_p4) * CS_W'(inv_p4);
			ba_g_p5 <= CS_W'(sc_g_p4) * CS_W'(inv_p4);
			ba_b_p5 <= CS_W'(sc_b_p4) * CS_W'(inv_p4);
			bb_r_p5 <= CS_W'(mist_red_q) * CS_W'(fog_p4);
			bb_g_p5 <= CS_W'(mist_green_q) * CS_W'(fog_p4);
			bb_b_p5 <= CS_W'(mist_blue_q) * CS_W'(fog_p4);

			alpha_p6 <= col_p5.alpha;
			out_r_p6 <= blend_out(ba_r_p5, bb_r_p5);
			out_g_p6 <= blend_out(ba_g_p5, bb_g_p5);
			out_b_p6 <= blend_out(ba_b_p5, bb_b_p5);
		end
	end

	assign m_axis_tvalid = v_p6;
	assign m_axis_tdata  = {alpha_p6, out_b_p6, out_g_p6, out_r_p6};

`ifndef SYNTHESIS
	// near band carries a zero offset, so both quotients must be zero
	a_near_zero_q: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld && div_res.side.band == BAND_NEAR |-> div_res.q_a == '0 && div_res.q_b == '0)
		else $error("near band produced a nonzero quotient");

	// quotient never exceeds the drop of its band
	a_drop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld && div_res.side.band == BAND_SHADE |-> div_res.q_a <= DROP1_Q)
		else $error("shade drop above band drop");

	a_mist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld && div_res.side.band == BAND_MIST |->
		div_res.q_a <= DROP2_Q && div_res.q_b <= ONE_Q)
		else $error("mist quotient out of range");

	// shade stays within its floor and 1.0, fog within 1.0
	a_shade_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_p1 |-> shade_p1 >= K35_Q && shade_p1 <= ONE_Q && fog_p1 <= ONE_Q)
		else $error("shade or fog factor out of range");
`endif

endmodule
